@@ sv/lsp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsp_pkg
// Shared types, codes and defaults of the looping sample player.
// ----------------------------------------------------------------------------
package lsp_pkg;

	localparam int BUFFER_FRAMES_DEF = 65536;
	localparam int FRAC_BITS_DEF     = 16;
	localparam int SAMPLE_BITS_DEF   = 16;

	// fixed register field widths
	localparam int RATE_W    = 24;
	localparam int FRAMES_W  = 17;
	localparam int LSTART_W  = 16;
	localparam int CHAN_W    = 2;
	localparam int PADDR_W   = 5;
	localparam int PDATA_W   = 32;

	localparam logic [RATE_W-1:0] RATE_STEP_RST       = 24'd65536;
	localparam logic [CHAN_W-1:0] BUFFER_CHANNELS_RST = 2'd1;
	localparam logic [CHAN_W-1:0] OUTPUT_CHANNELS_RST = 2'd2;

	typedef enum logic [1:0] {
		MODE_TICK  = 2'd0,
		MODE_LOAD  = 2'd1,
		MODE_START = 2'd2,
		MODE_STOP  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_RATE_STEP       = 3'd0,
		REG_LOOP_ENABLE     = 3'd1,
		REG_LOOP_START      = 3'd2,
		REG_LOOP_END        = 3'd3,
		REG_BUFFER_FRAMES   = 3'd4,
		REG_BUFFER_CHANNELS = 3'd5,
		REG_OUTPUT_CHANNELS = 3'd6
	} reg_idx_t;

	// how the stored samples of a frame reach the output
	typedef enum logic [2:0] {
		MAP_ZERO   = 3'd0,
		MAP_MONO   = 3'd1,
		MAP_STEREO = 3'd2,
		MAP_DUP    = 3'd3,
		MAP_MIX    = 3'd4
	} map_t;

	typedef struct packed {
		logic [RATE_W-1:0]   rate_step;
		logic                loop_enable;
		logic [LSTART_W-1:0] loop_start;
		logic [FRAMES_W-1:0] loop_end;
		logic [FRAMES_W-1:0] buffer_frames;
		logic [CHAN_W-1:0]   buffer_channels;
		logic [CHAN_W-1:0]   output_channels;
	} cfg_t;

endpackage

@@ sv/looping_sample_player.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// looping_sample_player
// One sample-playback voice with loop points and channel mapping.
// ----------------------------------------------------------------------------
// The voice takes one item per clock. Load, start and stop items act in the
// cycle they are accepted and give no result. A tick item gives one output
// frame: in the accept cycle the position is checked against the loop points,
// advanced by rate_step and the sample store is addressed; the store's
// registered read data is then mapped and lands in the output register. A tick
// waits only while a stalled frame fills both the read stage and the output
// register; other items are never held. The store is split into an even and an
// odd bank so a stereo frame comes out in one read. Its contents are undefined
// until loaded, so no clearing pass runs after reset. Configuration may be
// written only while the voice is idle.
module looping_sample_player
	import lsp_pkg::*;
#(
	parameter int BUFFER_FRAMES = BUFFER_FRAMES_DEF,
	parameter int FRAC_BITS     = FRAC_BITS_DEF,
	parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
	localparam int ADDR_W       = $clog2(2 * BUFFER_FRAMES)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// item channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    mode,
	input  logic [ADDR_W-1:0]             load_address,
	input  logic signed [SAMPLE_BITS-1:0] load_sample,
	// frame channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] left_sample,
	output logic signed [SAMPLE_BITS-1:0] right_sample,
	output logic                          playing,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [PADDR_W-1:0]            paddr,
	input  logic [PDATA_W-1:0]            pwdata,
	output logic [PDATA_W-1:0]            prdata,
	output logic                          pready
);

	localparam int ROW_W     = $clog2(BUFFER_FRAMES);
	localparam int RATE_SPAN = 1 << (RATE_W - FRAC_BITS);
	localparam int IPOS_A    = $clog2(BUFFER_FRAMES + RATE_SPAN + 1);
	localparam int IPOS_W    = (IPOS_A > ROW_W) ? IPOS_A : ROW_W + 1;
	localparam int POS_W     = IPOS_W + FRAC_BITS;
	localparam int FW        = (IPOS_W > FRAMES_W) ? IPOS_W : FRAMES_W;

	cfg_t cfg;

	lsp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// playback state
	logic [POS_W-1:0] pos_q;
	logic             active_q;

	// stage 1: store read in flight
	logic             valid_s1;
	map_t             kind_s1;
	logic             playing_s1;
	logic             odd_s1;

	// output register
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] left_q;
	logic signed [SAMPLE_BITS-1:0] right_q;
	logic                          playing_q;

	logic in_acc;
	logic tick_acc;
	logic load_acc;
	logic s1_adv;

	assign s1_adv   = !out_valid_q || out_ready;
	assign in_ready = (mode != MODE_TICK) || !valid_s1 || s1_adv;
	assign in_acc   = in_valid && in_ready;
	assign tick_acc = in_acc && (mode == MODE_TICK);
	assign load_acc = in_acc && (mode == MODE_LOAD);

	// loop point clamping and the position step
	logic [FW-1:0]    bf, bf_m1, ls, ls_p1, le_sel, le_cap, le;
	logic [FW-1:0]    ipos, rd_pos;
	logic             run, end_hit, wrap, halt;
	logic [POS_W-1:0] base_pos, next_pos;
	map_t             kind;
	logic [ROW_W-1:0] rd_row;

	always_comb begin
		bf     = (FW'(cfg.buffer_frames) > FW'(BUFFER_FRAMES))
			? FW'(BUFFER_FRAMES) : FW'(cfg.buffer_frames);
		bf_m1  = bf - FW'(1);
		ls     = (FW'(cfg.loop_start) < bf_m1) ? FW'(cfg.loop_start) : bf_m1;
		ls_p1  = ls + FW'(1);
		le_sel = (cfg.loop_end != '0) ? FW'(cfg.loop_end) : bf;
		le_cap = (le_sel > bf) ? bf : le_sel;
		le     = (le_cap < ls_p1) ? ls_p1 : le_cap;

		ipos    = FW'(pos_q[POS_W-1:FRAC_BITS]);
		run     = active_q && (bf != '0) && (cfg.buffer_channels != '0);
		end_hit = ipos >= bf;
		halt    = end_hit && !cfg.loop_enable;
		wrap    = end_hit || (cfg.loop_enable && (ipos >= le));
		rd_pos  = wrap ? ls : ipos;

		base_pos = wrap ? {ls[IPOS_W-1:0], {FRAC_BITS{1'b0}}} : pos_q;
		next_pos = base_pos + POS_W'(cfg.rate_step);

		if (cfg.buffer_channels == cfg.output_channels) begin
			unique case (cfg.buffer_channels)
				2'd1:    kind = MAP_MONO;
				2'd2:    kind = MAP_STEREO;
				default: kind = MAP_ZERO;
			endcase
		end else if (cfg.buffer_channels == 2'd1 && cfg.output_channels == 2'd2) begin
			kind = MAP_DUP;
		end else if (cfg.buffer_channels == 2'd2 && cfg.output_channels == 2'd1) begin
			kind = MAP_MIX;
		end else begin
			kind = MAP_ZERO;
		end

		// stereo frames sit in one row of both banks, mono samples alternate
		rd_row = (cfg.buffer_channels == 2'd2) ? rd_pos[ROW_W-1:0] : rd_pos[ROW_W:1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			active_q <= 1'b0;
		end else if (in_acc) begin
			unique case (mode)
				MODE_TICK: begin
					if (run) begin
						if (halt) begin
							active_q <= 1'b0;
						end else begin
							pos_q <= next_pos;
						end
					end
				end
				MODE_LOAD: ;
				MODE_START: begin
					pos_q    <= '0;
					active_q <= 1'b1;
				end
				MODE_STOP: active_q <= 1'b0;
				default: ;
			endcase
		end
	end

	// sample store, even and odd interleaved entries
	logic                   ld_in_range;
	logic                   we_even, we_odd;
	logic [SAMPLE_BITS-1:0] even_rd, odd_rd;

	assign ld_in_range = {1'b0, load_address} < (ADDR_W + 1)'(2 * BUFFER_FRAMES);
	assign we_even     = load_acc && ld_in_range && !load_address[0];
	assign we_odd      = load_acc && ld_in_range && load_address[0];

	lsp_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (BUFFER_FRAMES)
	) u_even_bank (
		.clk   (clk),
		.we    (we_even),
		.waddr (load_address[ADDR_W-1:1]),
		.wdata (load_sample),
		.re    (tick_acc),
		.raddr (rd_row),
		.rdata (even_rd)
	);

	lsp_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (BUFFER_FRAMES)
	) u_odd_bank (
		.clk   (clk),
		.we    (we_odd),
		.waddr (load_address[ADDR_W-1:1]),
		.wdata (load_sample),
		.re    (tick_acc),
		.raddr (rd_row),
		.rdata (odd_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= tick_acc || (valid_s1 && !s1_adv);
		end
	end

	always_ff @(posedge clk) begin
		if (tick_acc) begin
			kind_s1    <= (run && !halt) ? kind : MAP_ZERO;
			playing_s1 <= run && !halt;
			odd_s1     <= rd_pos[0];
		end
	end

	// channel mapping on the store output
	logic signed [SAMPLE_BITS-1:0] even_s, odd_s, mono_s, mix_s;
	logic signed [SAMPLE_BITS:0]   sum_s;
	logic signed [SAMPLE_BITS-1:0] left_d, right_d;

	always_comb begin
		even_s = even_rd;
		odd_s  = odd_rd;
		mono_s = odd_s1 ? odd_s : even_s;
		sum_s  = {even_s[SAMPLE_BITS-1], even_s} + {odd_s[SAMPLE_BITS-1], odd_s};
		mix_s  = sum_s[SAMPLE_BITS:1];
		unique case (kind_s1)
			MAP_MONO: begin
				left_d  = mono_s;
				right_d = '0;
			end
			MAP_STEREO: begin
				left_d  = even_s;
				right_d = odd_s;
			end
			MAP_DUP: begin
				left_d  = mono_s;
				right_d = mono_s;
			end
			MAP_MIX: begin
				left_d  = mix_s;
				right_d = '0;
			end
			default: begin
				left_d  = '0;
				right_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && valid_s1) begin
			left_q    <= left_d;
			right_q   <= right_d;
			playing_q <= playing_s1;
		end
	end

	assign out_valid    = out_valid_q;
	assign left_sample  = left_q;
	assign right_sample = right_q;
	assign playing      = playing_q;

endmodule

@@ sv/lsp_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsp_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lsp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// hold read data between reads
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ sv/lsp_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsp_regs
// APB register file holding the playback configuration.
// ----------------------------------------------------------------------------
module lsp_regs
	import lsp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rate_step       <= RATE_STEP_RST;
			cfg_q.loop_enable     <= 1'b0;
			cfg_q.loop_start      <= '0;
			cfg_q.loop_end        <= '0;
			cfg_q.buffer_frames   <= '0;
			cfg_q.buffer_channels <= BUFFER_CHANNELS_RST;
			cfg_q.output_channels <= OUTPUT_CHANNELS_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_RATE_STEP:       cfg_q.rate_step       <= pwdata[RATE_W-1:0];
				REG_LOOP_ENABLE:     cfg_q.loop_enable     <= pwdata[0];
				REG_LOOP_START:      cfg_q.loop_start      <= pwdata[LSTART_W-1:0];
				REG_LOOP_END:        cfg_q.loop_end        <= pwdata[FRAMES_W-1:0];
				REG_BUFFER_FRAMES:   cfg_q.buffer_frames   <= pwdata[FRAMES_W-1:0];
				REG_BUFFER_CHANNELS: cfg_q.buffer_channels <= pwdata[CHAN_W-1:0];
				REG_OUTPUT_CHANNELS: cfg_q.output_channels <= pwdata[CHAN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_RATE_STEP:       prdata = PDATA_W'(cfg_q.rate_step);
			REG_LOOP_ENABLE:     prdata = PDATA_W'(cfg_q.loop_enable);
			REG_LOOP_START:      prdata = PDATA_W'(cfg_q.loop_start);
			REG_LOOP_END:        prdata = PDATA_W'(cfg_q.loop_end);
			REG_BUFFER_FRAMES:   prdata = PDATA_W'(cfg_q.buffer_frames);
			REG_BUFFER_CHANNELS: prdata = PDATA_W'(cfg_q.buffer_channels);
			REG_OUTPUT_CHANNELS: prdata = PDATA_W'(cfg_q.output_channels);
			default:             prdata = '0;
		endcase
	end

endmodule

@@ sv/lsp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsp_checker
// Port-level checks of the looping sample player, bound to the top level.
// ----------------------------------------------------------------------------
module lsp_checker
	import lsp_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic [1:0]                    mode,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic signed [SAMPLE_BITS-1:0] left_sample,
	input logic signed [SAMPLE_BITS-1:0] right_sample,
	input logic                          playing
);

	logic tick_beat;

	assign tick_beat = in_valid && in_ready && (mode == MODE_TICK);

	// a stalled frame holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(left_sample)
			&& $stable(right_sample) && $stable(playing))
		else $error("stalled output frame changed");

	// silent frames carry zeros
	a_silent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !playing |-> left_sample == '0 && right_sample == '0)
		else $error("silent frame with nonzero samples");

	// a frame comes only from an earlier tick beat
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!tick_beat ##1 !out_valid |=> !out_valid)
		else $error("output frame without a tick beat");

	// never stall input while the output register is free
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

endmodule

bind looping_sample_player lsp_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_lsp_checker (.*);
